// ===== rtl/csfe_pkg.sv =====
// Shared types and constants for the character frequency histogram block.
package csfe_pkg;

   localparam int BIN_COUNT = 96;
   localparam int BIN_IDX_W = 7;
   localparam int COUNT_W = 7;
   localparam logic [7:0] FIRST_CODE = 8'd32;
   localparam logic [7:0] SPACE_CODE = 8'd32;
   localparam logic [BIN_IDX_W-1:0] LAST_BIN = BIN_IDX_W'(BIN_COUNT - 1);

   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [6:0]         letter;
      logic [COUNT_W-1:0] occurrences;
      logic               is_most;
      logic               is_least;
      logic [COUNT_W-1:0] max_count;
      logic [COUNT_W-1:0] min_count;
      logic [COUNT_W-1:0] max_kinds;
      logic [COUNT_W-1:0] min_kinds;
      logic               overflow;
      logic               empty_res;
      logic               final_res;
   } rsp_type;

   typedef logic [7:0] csr_type;

   typedef struct packed {
      logic load;
      logic scan_init;
      logic scan;
      logic emit_init;
      logic emit_read;
      logic emit_next;
      logic emit_load;
      logic emit_empty;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic last_transfer;
      logic scan_end;
      logic no_kinds;
      logic bin_nonzero;
      logic bin_is_final;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/csfe_stream_if.sv =====
// Valid/ready channel carrying one payload per transfer.
interface csfe_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/csfe_ctrl.sv =====
// Sequencer for load, drain, scan, emit and clear phases.
module csfe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  csfe_pkg::status_type  status,
   output csfe_pkg::cmd_type     cmd
);

   typedef enum logic [7:0] {
      ST_LOAD       = 8'b0000_0001,
      ST_DRAIN      = 8'b0000_0010,
      ST_SCAN       = 8'b0000_0100,
      ST_EMIT_START = 8'b0000_1000,
      ST_EMPTY      = 8'b0001_0000,
      ST_EMIT_RD    = 8'b0010_0000,
      ST_EMIT_CHK   = 8'b0100_0000,
      ST_CLEAR      = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_LOAD: begin
            cmd.load = 1'b1;
            if (status.last_transfer) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.scan_init = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_end) begin
               state_in = ST_EMIT_START;
            end
         end
         ST_EMIT_START: begin
            cmd.emit_init = 1'b1;
            state_in = status.no_kinds ? ST_EMPTY : ST_EMIT_RD;
         end
         ST_EMPTY: begin
            if (status.out_free) begin
               cmd.emit_empty = 1'b1;
               state_in = ST_CLEAR;
            end
         end
         ST_EMIT_RD: begin
            cmd.emit_read = 1'b1;
            state_in = ST_EMIT_CHK;
         end
         ST_EMIT_CHK: begin
            if (!status.bin_nonzero) begin
               cmd.emit_next = 1'b1;
               state_in = ST_EMIT_RD;
            end else if (status.out_free) begin
               cmd.emit_load = 1'b1;
               cmd.emit_next = 1'b1;
               state_in = status.bin_is_final ? ST_CLEAR : ST_EMIT_RD;
            end
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/csfe_datapath.sv =====
// Histogram memory, byte filter, extreme-count scan and result register.
module csfe_datapath #(
   parameter int CAPACITY = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  csfe_pkg::cmd_type    cmd,
   output csfe_pkg::status_type status,
   csfe_stream_if.sink          req_chan,
   csfe_stream_if.source        rsp_chan,
   csfe_stream_if.sink          csr_chan
);

   localparam int IW = csfe_pkg::BIN_IDX_W;
   localparam int CW = csfe_pkg::COUNT_W;

   logic [CW-1:0] hist_mem [csfe_pkg::BIN_COUNT];
   logic [csfe_pkg::BIN_COUNT-1:0] hist_vld_ff, hist_vld_in;

   logic [7:0]    drop_spaces_ff, drop_spaces_in;
   logic [7:0]    spaces_left_ff, spaces_left_in;
   logic          in_set_ff, in_set_in;
   logic [CW-1:0] kept_total_ff, kept_total_in;
   logic          overflowed_ff, overflowed_in;

   logic          s2_valid_ff;
   logic [IW-1:0] s2_addr_ff;
   logic          fwd_valid_ff;
   logic [IW-1:0] fwd_addr_ff;
   logic [CW-1:0] fwd_val_ff;
   logic [CW-1:0] rd_data_ff;

   logic [IW-1:0] scan_ptr_ff, scan_ptr_in;
   logic          proc_valid_ff;
   logic [IW-1:0] proc_idx_ff;
   logic          any_ff, any_in;
   logic [CW-1:0] max_ff, max_in, min_ff, min_in;
   logic [CW-1:0] maxk_ff, maxk_in, mink_ff, mink_in;
   logic [IW-1:0] last_idx_ff, last_idx_in;
   logic [IW-1:0] emit_ptr_ff, emit_ptr_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   csfe_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic          req_fire;
   logic [7:0]    sym;
   logic          printable;
   logic [7:0]    spaces_eff;
   logic          drop_space;
   logic          cap_full;
   logic          keep;
   logic          scan_rd;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] sym_idx;
   logic [CW-1:0] s2_old;
   logic [CW-1:0] s2_new;
   logic [CW-1:0] scan_cnt;
   logic          out_free;

   assign req_chan.ready = cmd.load;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   assign req_fire = req_chan.valid && cmd.load;
   assign sym = req_chan.payload.symbol;
   assign printable = !sym[7] && (sym >= csfe_pkg::FIRST_CODE);
   assign spaces_eff = in_set_ff ? spaces_left_ff : drop_spaces_ff;
   assign drop_space = (sym == csfe_pkg::SPACE_CODE) && (spaces_eff != 8'd0);
   assign cap_full = kept_total_ff >= CW'(CAPACITY);
   assign keep = printable && !drop_space && !cap_full;
   assign sym_idx = sym[IW-1:0] - csfe_pkg::FIRST_CODE[IW-1:0];

   assign scan_rd = cmd.scan && (scan_ptr_ff < IW'(csfe_pkg::BIN_COUNT));
   assign rd_en = (req_fire && keep) || scan_rd || cmd.emit_read;

   always_comb begin
      if (cmd.load) begin
         rd_addr = sym_idx;
      end else if (cmd.scan) begin
         rd_addr = scan_ptr_ff;
      end else begin
         rd_addr = emit_ptr_ff;
      end
   end

   // stage two: increment with bypass of the write made at the read edge
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s2_addr_ff)) begin
         s2_old = fwd_val_ff;
      end else if (hist_vld_ff[s2_addr_ff]) begin
         s2_old = rd_data_ff;
      end else begin
         s2_old = '0;
      end
      s2_new = s2_old + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
      if (s2_valid_ff) begin
         hist_mem[s2_addr_ff] <= s2_new;
      end
   end

   assign scan_cnt = hist_vld_ff[proc_idx_ff] ? rd_data_ff : '0;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      hist_vld_in = hist_vld_ff;
      drop_spaces_in = drop_spaces_ff;
      spaces_left_in = spaces_left_ff;
      in_set_in = in_set_ff;
      kept_total_in = kept_total_ff;
      overflowed_in = overflowed_ff;
      scan_ptr_in = scan_ptr_ff;
      any_in = any_ff;
      max_in = max_ff;
      min_in = min_ff;
      maxk_in = maxk_ff;
      mink_in = mink_ff;
      last_idx_in = last_idx_ff;
      emit_ptr_in = emit_ptr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;

      if (csr_chan.valid) begin
         drop_spaces_in = csr_chan.payload;
      end

      if (req_fire) begin
         in_set_in = 1'b1;
         spaces_left_in = drop_space ? spaces_eff - 8'd1 : spaces_eff;
         if (keep) begin
            kept_total_in = kept_total_ff + CW'(1);
         end
         if (printable && !drop_space && cap_full) begin
            overflowed_in = 1'b1;
         end
      end

      if (s2_valid_ff) begin
         hist_vld_in[s2_addr_ff] = 1'b1;
      end

      if (cmd.scan_init) begin
         scan_ptr_in = '0;
         any_in = 1'b0;
         max_in = '0;
         min_in = '1;
         maxk_in = '0;
         mink_in = '0;
         last_idx_in = '0;
      end
      if (scan_rd) begin
         scan_ptr_in = scan_ptr_ff + IW'(1);
      end
      if (proc_valid_ff && (scan_cnt != '0)) begin
         any_in = 1'b1;
         last_idx_in = proc_idx_ff;
         if (scan_cnt > max_ff) begin
            max_in = scan_cnt;
            maxk_in = CW'(1);
         end else if (scan_cnt == max_ff) begin
            maxk_in = maxk_ff + CW'(1);
         end
         if (scan_cnt < min_ff) begin
            min_in = scan_cnt;
            mink_in = CW'(1);
         end else if (scan_cnt == min_ff) begin
            mink_in = mink_ff + CW'(1);
         end
      end

      if (cmd.emit_init) begin
         emit_ptr_in = '0;
      end else if (cmd.emit_next) begin
         emit_ptr_in = emit_ptr_ff + IW'(1);
      end

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.letter = emit_ptr_ff + csfe_pkg::FIRST_CODE[6:0];
         rsp_data_in.occurrences = rd_data_ff;
         rsp_data_in.is_most = rd_data_ff == max_ff;
         rsp_data_in.is_least = rd_data_ff == min_ff;
         rsp_data_in.max_count = max_ff;
         rsp_data_in.min_count = min_ff;
         rsp_data_in.max_kinds = maxk_ff;
         rsp_data_in.min_kinds = mink_ff;
         rsp_data_in.overflow = overflowed_ff;
         rsp_data_in.empty_res = 1'b0;
         rsp_data_in.final_res = emit_ptr_ff == last_idx_ff;
      end else if (cmd.emit_empty) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = '0;
         rsp_data_in.empty_res = 1'b1;
         rsp_data_in.final_res = 1'b1;
      end

      if (cmd.clear) begin
         hist_vld_in = '0;
         spaces_left_in = '0;
         in_set_in = 1'b0;
         kept_total_in = '0;
         overflowed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
         drop_spaces_ff <= '0;
         spaces_left_ff <= '0;
         in_set_ff <= 1'b0;
         kept_total_ff <= '0;
         overflowed_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
         proc_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hist_vld_ff <= hist_vld_in;
         drop_spaces_ff <= drop_spaces_in;
         spaces_left_ff <= spaces_left_in;
         in_set_ff <= in_set_in;
         kept_total_ff <= kept_total_in;
         overflowed_ff <= overflowed_in;
         s2_valid_ff <= req_fire && keep;
         fwd_valid_ff <= s2_valid_ff;
         proc_valid_ff <= scan_rd;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_addr_ff <= sym_idx;
      fwd_addr_ff <= s2_addr_ff;
      fwd_val_ff <= s2_new;
      proc_idx_ff <= scan_ptr_ff;
      scan_ptr_ff <= scan_ptr_in;
      any_ff <= any_in;
      max_ff <= max_in;
      min_ff <= min_in;
      maxk_ff <= maxk_in;
      mink_ff <= mink_in;
      last_idx_ff <= last_idx_in;
      emit_ptr_ff <= emit_ptr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.last_transfer = req_fire && req_chan.payload.last;
   assign status.scan_end = proc_valid_ff && (proc_idx_ff == csfe_pkg::LAST_BIN);
   assign status.no_kinds = !any_ff;
   assign status.bin_nonzero = hist_vld_ff[emit_ptr_ff];
   assign status.bin_is_final = emit_ptr_ff == last_idx_ff;
   assign status.out_free = out_free;

endmodule

// ===== rtl/char_sort_frequency_extremes_unit.sv =====
// Character frequency histogram: top level joining sequencer and datapath.
//
// req_chan takes one text byte per transfer, with last marking the end of a set.
// Printable codes 32..127 are counted, apart from the first drop_spaces spaces
// and any byte past CAPACITY kept bytes (which sets the overflow flag).
// csr_chan writes drop_spaces; it is always ready and is read at a set's first byte.
// rsp_chan gives one result per distinct symbol in ascending code order, or a
// single empty result; final_res marks the last one of the set.
// Throughput: one byte per cycle while a set loads (two-stage read-modify-write
// on the histogram memory with a bypass). After the last byte come a drain step,
// a scan of the 96 bins for extremes, a setup step, then a read and a check for
// each bin walked up to the highest used symbol (or a single empty result), and
// a clear. The next set's bytes are taken once the clear is done, even while the
// final result still waits in the output register.
// A stalled receiver holds the result register and pauses the walk over the bins.
// Reset (synchronous) clears the histogram valid bits, counters and drop_spaces.
module char_sort_frequency_extremes_unit #(
   parameter int CAPACITY = 64
) (
   input  logic          clock,
   input  logic          reset,
   csfe_stream_if.sink   req_chan,
   csfe_stream_if.source rsp_chan,
   csfe_stream_if.sink   csr_chan
);

   csfe_pkg::cmd_type    cmd;
   csfe_pkg::status_type status;

   csfe_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   csfe_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   a_stop_after_last: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && req_chan.payload.last |=> !req_chan.ready)
      else $error("input taken directly after the last transfer of a set");

   a_empty_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.empty_res |-> rsp_chan.payload.final_res)
      else $error("empty result not marked final");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.payload.empty_res |->
         rsp_chan.payload.occurrences != '0 &&
         rsp_chan.payload.occurrences <= rsp_chan.payload.max_count &&
         rsp_chan.payload.occurrences >= rsp_chan.payload.min_count)
      else $error("symbol count outside the extreme counts");

   a_most_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.payload.empty_res |->
         rsp_chan.payload.is_most ==
            (rsp_chan.payload.occurrences == rsp_chan.payload.max_count))
      else $error("most-frequent flag disagrees with count");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the character frequency histogram unit.
`timescale 1ns / 1ps

module tb;

   localparam int SET_CAPACITY = 64;
   localparam int SCAN_GAP = 320;
   localparam int LONG_HOLD = 600;
   localparam int FAULT_SHOWN = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   csfe_stream_if #(.payload_type(csfe_pkg::req_type)) req_if ();
   csfe_stream_if #(.payload_type(csfe_pkg::rsp_type)) rsp_if ();
   csfe_stream_if #(.payload_type(csfe_pkg::csr_type)) csr_if ();

   char_sort_frequency_extremes_unit #(.CAPACITY(SET_CAPACITY)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   csfe_pkg::req_type text_queue[$];
   csfe_pkg::rsp_type expected_ranks[$];
   int unsigned       hist_bins[csfe_pkg::BIN_COUNT];
   int unsigned       kept_count = 0;
   logic [7:0]        spaces_to_drop = '0;
   csfe_pkg::csr_type drop_setting = '0;
   logic              set_open = 1'b0;
   logic              over_capacity = 1'b0;

   int   fault_count = 0;
   logic req_taken = 1'b0;
   logic calm = 1'b0;
   logic hold_request = 1'b0;
   logic rsp_hold = 1'b0;
   int   send_gap = 0;
   int   stall_left = 0;

   // Histogram update per byte; on the last byte, the sorted per-symbol ranking.
   task automatic tally_byte(input csfe_pkg::req_type item);
      int unsigned top_count, low_count, top_kinds, low_kinds, top_bin;
      csfe_pkg::rsp_type rank;
      if (!set_open) begin
         spaces_to_drop = drop_setting;
         set_open = 1'b1;
      end
      if (item.symbol >= csfe_pkg::FIRST_CODE && item.symbol[7] == 1'b0) begin
         if (item.symbol == csfe_pkg::SPACE_CODE && spaces_to_drop != 0) begin
            spaces_to_drop--;
         end else if (kept_count >= SET_CAPACITY) begin
            over_capacity = 1'b1;
         end else begin
            hist_bins[item.symbol - csfe_pkg::FIRST_CODE]++;
            kept_count++;
         end
      end
      if (item.last) begin
         top_count = 0;
         low_count = 255;
         top_kinds = 0;
         low_kinds = 0;
         top_bin = csfe_pkg::BIN_COUNT;
         foreach (hist_bins[b]) begin
            if (hist_bins[b] != 0) begin
               if (hist_bins[b] > top_count) top_count = hist_bins[b];
               if (hist_bins[b] < low_count) low_count = hist_bins[b];
               top_bin = b;
            end
         end
         rank = '0;
         if (top_bin == csfe_pkg::BIN_COUNT) begin
            rank.empty_res = 1'b1;
            rank.final_res = 1'b1;
            expected_ranks.push_back(rank);
         end else begin
            foreach (hist_bins[b]) begin
               if (hist_bins[b] == top_count) top_kinds++;
               if (hist_bins[b] == low_count) low_kinds++;
            end
            foreach (hist_bins[b]) begin
               if (hist_bins[b] != 0) begin
                  rank.letter = 7'(b + csfe_pkg::FIRST_CODE);
                  rank.occurrences = 7'(hist_bins[b]);
                  rank.is_most = (hist_bins[b] == top_count);
                  rank.is_least = (hist_bins[b] == low_count);
                  rank.max_count = 7'(top_count);
                  rank.min_count = 7'(low_count);
                  rank.max_kinds = 7'(top_kinds);
                  rank.min_kinds = 7'(low_kinds);
                  rank.overflow = over_capacity;
                  rank.final_res = (b == top_bin);
                  expected_ranks.push_back(rank);
               end
            end
         end
         foreach (hist_bins[b]) hist_bins[b] = 0;
         kept_count = 0;
         spaces_to_drop = '0;
         over_capacity = 1'b0;
         set_open = 1'b0;
      end
   endtask

   function automatic string describe(input csfe_pkg::rsp_type r);
      return $sformatf("letter=%0d occ=%0d most=%0b least=%0b max=%0d min=%0d %s",
                       r.letter, r.occurrences, r.is_most, r.is_least, r.max_count,
                       r.min_count, $sformatf("maxk=%0d mink=%0d ovf=%0b empty=%0b fin=%0b",
                       r.max_kinds, r.min_kinds, r.overflow, r.empty_res, r.final_res));
   endfunction

   task automatic log_fault(input string msg);
      fault_count++;
      if (fault_count <= FAULT_SHOWN) $display("%0t: %s", $realtime, msg);
   endtask

   task automatic queue_byte(input logic [7:0] code, input logic fin);
      text_queue.push_back(csfe_pkg::req_type'{symbol: code, last: fin});
   endtask

   // Random sets: mostly printable text over a small alphabet, with spaces and noise.
   task automatic queue_random_text(input int budget);
      logic [7:0] alphabet[8];
      logic [7:0] code;
      int span, len, pick;
      while (budget > 0) begin
         span = $urandom_range(1, 8);
         foreach (alphabet[i]) alphabet[i] = 8'($urandom_range(32, 127));
         pick = $urandom_range(0, 99);
         if (pick < 80) len = $urandom_range(1, 12);
         else if (pick < 96) len = $urandom_range(13, 40);
         else len = $urandom_range(60, 90);
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) code = alphabet[$urandom_range(0, span - 1)];
            else if (pick < 75) code = csfe_pkg::SPACE_CODE;
            else if (pick < 85) code = 8'($urandom_range(0, 31));
            else if (pick < 95) code = 8'($urandom_range(128, 255));
            else code = 8'($urandom_range(0, 255));
            queue_byte(code, i == len - 1);
         end
         budget -= len;
      end
   endtask

   task automatic settle();
      while (text_queue.size() != 0 || expected_ranks.size() != 0) @(posedge clock);
      repeat (SCAN_GAP) @(posedge clock);
   endtask

   task automatic write_drop(input csfe_pkg::csr_type value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.payload <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      drop_setting = value;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Sender
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!(req_if.valid && !req_taken)) begin
         req_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 3);
            req_if.valid <= 1'b0;
         end else if (text_queue.size() != 0) begin
            req_if.valid <= 1'b1;
            req_if.payload <= text_queue[0];
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver
   always @(negedge clock) begin
      if (reset || rsp_hold) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      wait (hold_request);
      rsp_hold = 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // Monitor: checks each result transfer, predicts on each byte transfer
   always @(posedge clock) begin
      csfe_pkg::rsp_type got, want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (expected_ranks.size() == 0) begin
               log_fault({"unexpected result: ", describe(got)});
            end else begin
               want = expected_ranks.pop_front();
               if (got.letter !== want.letter || got.occurrences !== want.occurrences ||
                   got.is_most !== want.is_most || got.is_least !== want.is_least ||
                   got.max_count !== want.max_count || got.min_count !== want.min_count ||
                   got.max_kinds !== want.max_kinds || got.min_kinds !== want.min_kinds ||
                   got.overflow !== want.overflow || got.empty_res !== want.empty_res ||
                   got.final_res !== want.final_res)
                  log_fault({"mismatch: expected ", describe(want), " got ", describe(got)});
            end
         end
         if (req_if.valid && req_if.ready) begin
            tally_byte(req_if.payload);
            void'(text_queue.pop_front());
            req_taken = 1'b1;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [7:0] codes[csfe_pkg::BIN_COUNT];
      logic [7:0] code, swap;
      int j;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.payload = '0;
      foreach (hist_bins[b]) hist_bins[b] = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_drop(8'd0);
      queue_byte("A", 1'b1);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b1);
      queue_byte(csfe_pkg::SPACE_CODE, 1'b0);
      queue_byte(8'd127, 1'b0);
      queue_byte(8'd31, 1'b0);
      queue_byte(8'd128, 1'b0);
      queue_byte(8'd127, 1'b1);
      queue_byte("b", 1'b0);
      queue_byte("a", 1'b0);
      queue_byte("b", 1'b1);
      settle();

      // leading spaces dropped
      write_drop(8'd2);
      queue_byte(csfe_pkg::SPACE_CODE, 1'b0);
      queue_byte(csfe_pkg::SPACE_CODE, 1'b0);
      queue_byte(csfe_pkg::SPACE_CODE, 1'b0);
      queue_byte("a", 1'b1);
      queue_byte(csfe_pkg::SPACE_CODE, 1'b1);
      settle();
      write_drop(8'd255);
      queue_byte(csfe_pkg::SPACE_CODE, 1'b0);
      queue_byte(csfe_pkg::SPACE_CODE, 1'b0);
      queue_byte(csfe_pkg::SPACE_CODE, 1'b0);
      queue_byte("z", 1'b1);
      settle();

      // receiver holds off while the sender keeps going
      write_drop(8'd1);
      hold_request = 1'b1;
      queue_random_text(55);
      settle();

      // capacity: every kind distinct, one symbol saturated, exactly full
      write_drop(8'd0);
      for (int i = 0; i < csfe_pkg::BIN_COUNT; i++) codes[i] = csfe_pkg::FIRST_CODE + 8'(i);
      for (int i = csfe_pkg::BIN_COUNT - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         swap = codes[i];
         codes[i] = codes[j];
         codes[j] = swap;
      end
      for (int i = 0; i < SET_CAPACITY; i++) queue_byte(codes[i], 1'b0);
      for (int i = 0; i < 3; i++)
         queue_byte(codes[$urandom_range(0, csfe_pkg::BIN_COUNT - 1)], i == 2);
      code = 8'($urandom_range(33, 127));
      for (int i = 0; i < 70; i++) queue_byte(code, i == 69);
      for (int i = 0; i < SET_CAPACITY; i++) queue_byte(codes[$urandom_range(0, 3)], 1'b0);
      queue_byte(8'h0A, 1'b1);
      settle();

      write_drop(8'd255);
      queue_random_text(45);
      settle();
      write_drop(8'd3);
      queue_random_text(45);
      settle();
      write_drop(8'd0);
      calm = 1'b1;
      queue_random_text(45);
      settle();

      if (fault_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== char_sort_frequency_extremes_unit.f =====
rtl/csfe_pkg.sv
rtl/csfe_stream_if.sv
rtl/csfe_ctrl.sv
rtl/csfe_datapath.sv
rtl/char_sort_frequency_extremes_unit.sv
tb/tb.sv
